/* rtl/cbsf_pkg.sv */
package cbsf_pkg;

  // Width of the line number field in decimal columns.
  localparam int NUMBER_DIGITS = 6;
  localparam int COUNT_W       = 4 * NUMBER_DIGITS;
  localparam int DIG_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  // Command queue between the front and back ends.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

  // Emission phases of one command: the digits, most significant first,
  // then the tab, the dollar, the caret and the data byte.
  localparam int PH_W = $clog2(NUMBER_DIGITS + 4);

  localparam logic [PH_W-1:0] PH_FIRST_DIGIT = '0;
  localparam logic [PH_W-1:0] PH_LAST_DIGIT  = PH_W'(NUMBER_DIGITS - 1);
  localparam logic [PH_W-1:0] PH_TAB         = PH_W'(NUMBER_DIGITS);
  localparam logic [PH_W-1:0] PH_DOLLAR      = PH_W'(NUMBER_DIGITS + 1);
  localparam logic [PH_W-1:0] PH_CARET       = PH_W'(NUMBER_DIGITS + 2);
  localparam logic [PH_W-1:0] PH_DATA        = PH_W'(NUMBER_DIGITS + 3);

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_CTRL_MAX = 8'd31;
  localparam logic [7:0] CH_DEL    = 8'd127;

  // One formatted item as handed from the front end to the back end.
  typedef struct packed {
    logic               put_number;  // line number and tab come first
    logic [COUNT_W-1:0] count;       // BCD line number to print
    logic               put_dollar;  // dollar before the data byte
    logic               put_caret;   // caret before the data byte
    logic [7:0]         data;        // final byte of the run
  } cmd_t;

endpackage

/* rtl/cat_byte_stream_formatter_core.sv */
// Byte stream formatter in the manner of the unix cat filter.
// Input channel: one text byte per transfer (in_byte) with in_new_file set
// on the first byte of each file; a transfer happens when in_valid is high
// and in_stall is low. Output channel: one formatted byte per transfer,
// with out_last_of_run marking the final byte produced for an input byte.
// Six configuration bits are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block
// does not enforce; unknown indexes are ignored. An accepted input is
// written into the command queue, and the back end loads its output bytes
// from the queue head into the output register. Throughput: one output byte
// per cycle from the back end while the receiver does not stall, so a byte
// that formats to a single output byte sustains one input per cycle; line
// numbers add six digits and a tab, a dollar or a caret one byte each.
// The input stalls only while the four-entry command queue is full.
// A dropped repeated blank line takes an input transfer and yields nothing.
// Reset (synchronous, rst_n low) clears all options, sets the line number
// to one, marks the start of a line and empties the queue and output.
// When the receiver stalls, the output register holds its byte, the back
// end stops, and the queue fills before in_stall is raised.
module cat_byte_stream_formatter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbsf_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           in_new_file,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run
);
  import cbsf_pkg::*;

  // Front end to queue.
  logic push;
  cmd_t push_cmd;
  logic fifo_full;

  // Queue to back end.
  cmd_t head_cmd;
  logic fifo_empty;
  logic pop;

  // The front end holds the options and the line state, decides whether a
  // byte is dropped and turns each kept byte into one command.
  cbsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_new_file (in_new_file),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // A short queue lets the front end run ahead while the back end spells
  // out a line number or an escape.
  cbsf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // The back end steps through the phases of the head command, one output
  // byte per cycle while out_stall allows, into a registered output stage.
  cbsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .empty           (fifo_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* rtl/cbsf_front.sv */
module cbsf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cbsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbsf_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            in_new_file,
  input  logic                            fifo_full,
  output logic                            push,
  output cbsf_pkg::cmd_t                  push_cmd
);
  import cbsf_pkg::*;

  localparam logic [COUNT_W-1:0] ALL_NINES = {NUMBER_DIGITS{4'h9}};

  logic number_all_r, number_nonblank_r, squeeze_blank_r;
  logic show_ends_r, show_tabs_r, show_nonprinting_r;

  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic               at_ls_r, at_ls_nxt;
  logic               blank_r, blank_nxt;

  logic accept, is_nl, piece, blank_eff, drop, do_num, is_ctrl, carry;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_all_r       <= 1'b0;
      number_nonblank_r  <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_ends_r        <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUMBER_ALL:       number_all_r       <= cfg_wdata[0];
        CFG_NUMBER_NONBLANK:  number_nonblank_r  <= cfg_wdata[0];
        CFG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_wdata[0];
        CFG_SHOW_ENDS:        show_ends_r        <= cfg_wdata[0];
        CFG_SHOW_TABS:        show_tabs_r        <= cfg_wdata[0];
        CFG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturating BCD increment, one digit position per step.
  always_comb begin
    count_inc = count_r;
    carry     = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (count_r[4*i +: 4] == 4'h9) begin
          count_inc[4*i +: 4] = 4'h0;
        end else begin
          count_inc[4*i +: 4] = count_r[4*i +: 4] + 4'h1;
          carry = 1'b0;
        end
      end
    end
    if (count_r == ALL_NINES) begin
      count_inc = count_r;
    end
  end

  always_comb begin
    in_stall  = fifo_full;
    accept    = in_valid && !in_stall;
    is_nl     = (in_byte == CH_NL);
    piece     = at_ls_r || in_new_file;
    blank_eff = in_new_file ? 1'b0 : blank_r;
    drop      = piece && squeeze_blank_r && is_nl && blank_eff;
    do_num    = at_ls_r && ((number_nonblank_r && !is_nl) ||
                            (number_all_r && !number_nonblank_r));
    is_ctrl   = ((in_byte <= CH_CTRL_MAX) && (in_byte != CH_TAB) && (in_byte != CH_NL)) ||
                (in_byte == CH_DEL);

    blank_nxt = blank_r;
    count_nxt = count_r;
    at_ls_nxt = at_ls_r;
    if (accept) begin
      blank_nxt = piece ? (squeeze_blank_r && is_nl) : blank_r;
      if (!drop) begin
        at_ls_nxt = is_nl;
        if (do_num) begin
          count_nxt = count_inc;
        end
      end
    end

    push                = accept && !drop;
    push_cmd.put_number = do_num;
    push_cmd.count      = count_r;
    push_cmd.put_dollar = show_ends_r && is_nl;
    if (show_tabs_r && (in_byte == CH_TAB)) begin
      push_cmd.put_caret = 1'b1;
      push_cmd.data      = CH_I;
    end else if (show_nonprinting_r && is_ctrl) begin
      push_cmd.put_caret = 1'b1;
      push_cmd.data      = (in_byte == CH_DEL) ? CH_QUEST : (CH_AT + in_byte);
    end else begin
      push_cmd.put_caret = 1'b0;
      push_cmd.data      = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(1);
      at_ls_r <= 1'b1;
      blank_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      at_ls_r <= at_ls_nxt;
      blank_r <= blank_nxt;
    end
  end

endmodule

/* rtl/cbsf_fifo.sv */
module cbsf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbsf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output cbsf_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);
  import cbsf_pkg::*;

  cmd_t             slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  always_comb begin
    full     = (fill_r == CNT_W'(FIFO_DEPTH));
    empty    = (fill_r == '0);
    head_cmd = slot_r[rd_ptr_r];
    fill_nxt = fill_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

/* rtl/cbsf_back.sv */
module cbsf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cbsf_pkg::cmd_t head_cmd,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run
);
  import cbsf_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [PH_W-1:0] ph_start, ph_cur, ph_next;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, byte_sel;
  logic            out_last_r, last_sel;
  logic            emit;
  logic [7:0]      digit_char [NUMBER_DIGITS];

  // Character for each digit column; leading zeros print as spaces.
  always_comb begin
    for (int p = 0; p < NUMBER_DIGITS; p++) begin
      if ((p != NUMBER_DIGITS - 1) &&
          ((head_cmd.count >> (4 * (NUMBER_DIGITS - 1 - p))) == '0)) begin
        digit_char[p] = CH_SPACE;
      end else begin
        digit_char[p] = CH_ZERO + {4'h0, head_cmd.count[4*(NUMBER_DIGITS-1-p) +: 4]};
      end
    end
  end

  always_comb begin
    priority if (head_cmd.put_number) ph_start = PH_FIRST_DIGIT;
    else if (head_cmd.put_dollar)     ph_start = PH_DOLLAR;
    else if (head_cmd.put_caret)      ph_start = PH_CARET;
    else                              ph_start = PH_DATA;

    ph_cur = busy_r ? phase_r : ph_start;

    priority if (ph_cur < PH_LAST_DIGIT) ph_next = ph_cur + PH_W'(1);
    else if (ph_cur == PH_LAST_DIGIT)    ph_next = PH_TAB;
    else if ((ph_cur == PH_TAB) && head_cmd.put_dollar) ph_next = PH_DOLLAR;
    else if ((ph_cur != PH_CARET) && head_cmd.put_caret) ph_next = PH_CARET;
    else                                 ph_next = PH_DATA;

    priority if (ph_cur <= PH_LAST_DIGIT) byte_sel = digit_char[ph_cur[DIG_W-1:0]];
    else if (ph_cur == PH_TAB)            byte_sel = CH_TAB;
    else if (ph_cur == PH_DOLLAR)         byte_sel = CH_DOLLAR;
    else if (ph_cur == PH_CARET)          byte_sel = CH_CARET;
    else                                  byte_sel = head_cmd.data;

    last_sel = (ph_cur == PH_DATA);
    emit     = !empty && (!out_valid_r || !out_stall);
    pop      = emit && last_sel;

    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (emit) begin
      busy_nxt  = !last_sel;
      phase_nxt = ph_next;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_FIRST_DIGIT;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule
